// ===== rtl/quadtree_range_extreme_query_defines.svh =====
// Assertion macros used by the checker file.
`ifndef QUADTREE_RANGE_EXTREME_QUERY_DEFINES_SVH
`define QUADTREE_RANGE_EXTREME_QUERY_DEFINES_SVH

// Clocked assertion with reset gating
`define QRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion of an implication that holds in the next cycle
`define QRE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/qre_pkg.sv =====
// ----------------------------------------------------------------------------
// qre_pkg
// Types, codes and the compare function of the quadtree range extreme query.
// ----------------------------------------------------------------------------
package qre_pkg;

    localparam int CW = 7;   // coordinate width
    localparam int VW = 32;  // value width

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] REG_ROW_COUNT  = 2'd0;
    localparam logic [1:0] REG_COL_COUNT  = 2'd1;
    localparam logic [1:0] REG_SELECT_MIN = 2'd2;

    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

    // one candidate cell, or the default point when valid is low
    typedef struct packed {
        logic                 valid;
        logic [CW-1:0]        row;
        logic [CW-1:0]        col;
        logic signed [VW-1:0] value;
    } cand_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [CW-1:0]        row_lo;
        logic [CW-1:0]        col_lo;
        logic [CW-1:0]        row_hi;
        logic [CW-1:0]        col_hi;
        logic signed [VW-1:0] cell_value;
    } in_item_t;

    typedef struct packed {
        logic [CW-1:0]        best_row;
        logic [CW-1:0]        best_col;
        logic signed [VW-1:0] best_value;
        logic                 is_default;
    } out_item_t;

    // keep a unless b is strictly better; invalid loses to everything
    function automatic cand_t pick(input cand_t a, input cand_t b, input logic sel_min);
        cand_t r;
        r = a;
        if (!b.valid)
        begin
            r = a;
        end
        else if (!a.valid)
        begin
            r = b;
        end
        else if (sel_min)
        begin
            r = (b.value < a.value) ? b : a;
        end
        else
        begin
            r = (a.value < b.value) ? b : a;
        end
        return r;
    endfunction

endpackage

// ===== rtl/qre_if.sv =====
// ----------------------------------------------------------------------------
// qre_in_if / qre_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface qre_in_if import qre_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qre_out_if import qre_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/quadtree_range_extreme_query.sv =====
// ----------------------------------------------------------------------------
// quadtree_range_extreme_query
// Grid of signed values with a quadtree of range maxima or minima over it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command item: load cell, build tree, point update or
//   rectangle query. out_ch returns exactly one result item per command.
//   cfg_we/cfg_index/cfg_data write row_count, col_count and select_min;
//   write them only while the block is idle.
// Timing:
//   One item is in flight at a time; in_ch.ready is low from acceptance
//   until its result has been taken. Build, update and query walk the tree
//   depth first; each visited node passes through a child step, a visit, a
//   memory read or final merge, and a return. Build visits every node; a
//   query descends only into nodes that its rectangle's edges cut, so a
//   large rectangle whose edges cut many nodes takes the longest.
// Reset:
//   Registers return to 64 x 64, max mode. Grid and tree memories are not
//   cleared; build after loading before any update or query.
// Stall:
//   The result stays on out_ch until taken; no new item is accepted meanwhile.
// ----------------------------------------------------------------------------
module quadtree_range_extreme_query
    import qre_pkg::*;
#(
    parameter int GRID_SIZE = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    qre_in_if.sink         in_ch,
    qre_out_if.source      out_ch,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [CW-1:0]  cfg_data
);

    localparam int TREE_NODES = (16 * GRID_SIZE * GRID_SIZE) / 3 + 2;
    localparam int KW         = $clog2(TREE_NODES);
    localparam int GRID_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW         = $clog2(GRID_DEPTH);
    localparam int SPW        = $clog2($clog2(GRID_SIZE) + 2);
    localparam int STK_D      = 1 << SPW;

    typedef struct packed {
        logic [KW-1:0] k;
        logic [CW-1:0] r1;
        logic [CW-1:0] c1;
        logic [CW-1:0] r2;
        logic [CW-1:0] c2;
        logic [2:0]    ch;
        cand_t         acc;
    } frame_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VISIT,
        S_RDWAIT,
        S_NEXT,
        S_RET,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [CW-1:0]        qr1_reg, qr1_next;
    logic [CW-1:0]        qc1_reg, qc1_next;
    logic [CW-1:0]        qr2_reg, qr2_next;
    logic [CW-1:0]        qc2_reg, qc2_next;
    logic signed [VW-1:0] val_reg, val_next;
    frame_t               cur_reg, cur_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    cand_t                ret_reg, ret_next;
    logic                 rd_grid_reg, rd_grid_next;
    out_item_t            out_reg, out_next;
    logic [CW-1:0]        nr_reg, nc_reg;
    logic                 smin_reg;
    frame_t               stk_reg [STK_D];

    logic                 push;
    logic                 tree_we;
    cand_t                tree_wdata;
    logic                 grid_we;
    logic [AW-1:0]        grid_waddr;
    logic [AW-1:0]        grid_raddr;
    cand_t                tree_q;
    logic signed [VW-1:0] grid_q;

    cand_t                tree_mem [TREE_NODES];
    logic signed [VW-1:0] grid_mem [GRID_DEPTH];

    // node decode helpers
    logic          is_empty, is_leaf, is_outside, is_disjoint, is_inside;
    logic [CW:0]   rsum, csum;
    logic [CW-1:0] rm, cm;
    logic [KW+1:0] child_k;
    frame_t        child, parent;
    cand_t         none_c;
    logic [CW-1:0] cfg_clamped;

    assign none_c = '0;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = out_reg;

    // classify the current node
    always_comb
    begin
        is_empty    = (cur_reg.r1 > cur_reg.r2) || (cur_reg.c1 > cur_reg.c2);
        is_leaf     = (cur_reg.r1 == cur_reg.r2) && (cur_reg.c1 == cur_reg.c2);
        is_outside  = (qr1_reg > cur_reg.r2) || (qc1_reg > cur_reg.c2) ||
                      (qr1_reg < cur_reg.r1) || (qc1_reg < cur_reg.c1);
        is_disjoint = (qr1_reg > cur_reg.r2) || (qc1_reg > cur_reg.c2) ||
                      (qr2_reg < cur_reg.r1) || (qc2_reg < cur_reg.c1);
        is_inside   = (qr1_reg <= cur_reg.r1) && (qc1_reg <= cur_reg.c1) &&
                      (cur_reg.r2 <= qr2_reg) && (cur_reg.c2 <= qc2_reg);
        rsum        = {1'b0, cur_reg.r1} + {1'b0, cur_reg.r2};
        csum        = {1'b0, cur_reg.c1} + {1'b0, cur_reg.c2};
        rm          = rsum[CW:1];
        cm          = csum[CW:1];
        child_k     = {cur_reg.k, 2'b00} - (KW+2)'(2) + (KW+2)'(cur_reg.ch[1:0]);
        parent      = stk_reg[sp_reg - SPW'(1)];
    end

    // bounds of the next child to visit
    always_comb
    begin
        child     = '0;
        child.k   = child_k[KW-1:0];
        child.ch  = 3'd0;
        child.acc = none_c;
        case (cur_reg.ch[1:0])
            2'd0:
            begin
                child.r1 = cur_reg.r1;
                child.c1 = cur_reg.c1;
                child.r2 = rm;
                child.c2 = cm;
            end
            2'd1:
            begin
                child.r1 = rm + 1'b1;
                child.c1 = cur_reg.c1;
                child.r2 = cur_reg.r2;
                child.c2 = cm;
            end
            2'd2:
            begin
                child.r1 = cur_reg.r1;
                child.c1 = cm + 1'b1;
                child.r2 = rm;
                child.c2 = cur_reg.c2;
            end
            default:
            begin
                child.r1 = rm + 1'b1;
                child.c1 = cm + 1'b1;
                child.r2 = cur_reg.r2;
                child.c2 = cur_reg.c2;
            end
        endcase
    end

    assign grid_raddr = AW'(AW'(cur_reg.r1 - 1'b1) * AW'(GRID_SIZE)) +
                        AW'(cur_reg.c1 - 1'b1);
    assign grid_waddr = AW'(AW'(in_ch.data.row_lo - 1'b1) * AW'(GRID_SIZE)) +
                        AW'(in_ch.data.col_lo - 1'b1);

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        qr1_next     = qr1_reg;
        qc1_next     = qc1_reg;
        qr2_next     = qr2_reg;
        qc2_next     = qc2_reg;
        val_next     = val_reg;
        cur_next     = cur_reg;
        sp_next      = sp_reg;
        ret_next     = ret_reg;
        rd_grid_next = rd_grid_reg;
        out_next     = out_reg;
        push         = 1'b0;
        tree_we      = 1'b0;
        tree_wdata   = ret_reg;
        grid_we      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next = in_ch.data.command;
                    qr1_next = in_ch.data.row_lo;
                    qc1_next = in_ch.data.col_lo;
                    qr2_next = in_ch.data.row_hi;
                    qc2_next = in_ch.data.col_hi;
                    val_next = in_ch.data.cell_value;
                    if (in_ch.data.command == CMD_LOAD)
                    begin
                        grid_we = (in_ch.data.row_lo != '0) && (in_ch.data.col_lo != '0) &&
                                  (int'(in_ch.data.row_lo) <= GRID_SIZE) &&
                                  (int'(in_ch.data.col_lo) <= GRID_SIZE);
                        out_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cur_next.k   = KW'(1);
                        cur_next.r1  = CW'(1);
                        cur_next.c1  = CW'(1);
                        cur_next.r2  = nr_reg;
                        cur_next.c2  = nc_reg;
                        cur_next.ch  = 3'd0;
                        cur_next.acc = none_c;
                        sp_next      = '0;
                        state_next   = S_VISIT;
                    end
                end
            end

            S_VISIT:
            begin
                cur_next.ch  = 3'd0;
                cur_next.acc = none_c;
                if (is_empty)
                begin
                    ret_next   = none_c;
                    state_next = S_RET;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_BUILD:
                        begin
                            if (is_leaf)
                            begin
                                rd_grid_next = 1'b1;
                                state_next   = S_RDWAIT;
                            end
                            else
                            begin
                                state_next = S_NEXT;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (is_outside)
                            begin
                                rd_grid_next = 1'b0;
                                state_next   = S_RDWAIT;
                            end
                            else if (is_leaf)
                            begin
                                ret_next   = '{valid: 1'b1, row: qr1_reg, col: qc1_reg,
                                               value: val_reg};
                                tree_we    = 1'b1;
                                tree_wdata = '{valid: 1'b1, row: qr1_reg, col: qc1_reg,
                                               value: val_reg};
                                state_next = S_RET;
                            end
                            else
                            begin
                                state_next = S_NEXT;
                            end
                        end
                        default:
                        begin
                            if (is_disjoint)
                            begin
                                ret_next   = none_c;
                                state_next = S_RET;
                            end
                            else if (is_inside)
                            begin
                                rd_grid_next = 1'b0;
                                state_next   = S_RDWAIT;
                            end
                            else
                            begin
                                state_next = S_NEXT;
                            end
                        end
                    endcase
                end
            end

            S_RDWAIT:
            begin
                if (rd_grid_reg)
                begin
                    ret_next   = '{valid: 1'b1, row: cur_reg.r1, col: cur_reg.c1,
                                   value: grid_q};
                    tree_we    = 1'b1;
                    tree_wdata = '{valid: 1'b1, row: cur_reg.r1, col: cur_reg.c1,
                                   value: grid_q};
                end
                else
                begin
                    ret_next = tree_q;
                end
                state_next = S_RET;
            end

            S_NEXT:
            begin
                if (cur_reg.ch == 3'd4)
                begin
                    tree_we    = (cmd_reg != CMD_QUERY);
                    tree_wdata = cur_reg.acc;
                    ret_next   = cur_reg.acc;
                    state_next = S_RET;
                end
                else
                begin
                    push       = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    cur_next   = child;
                    state_next = S_VISIT;
                end
            end

            S_RET:
            begin
                if (sp_reg == '0)
                begin
                    if (ret_reg.valid)
                    begin
                        out_next = '{best_row: ret_reg.row, best_col: ret_reg.col,
                                     best_value: ret_reg.value, is_default: 1'b0};
                    end
                    else
                    begin
                        out_next = '{best_row: '0, best_col: '0,
                                     best_value: smin_reg ? VAL_MAX : VAL_MIN,
                                     is_default: 1'b1};
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    cur_next     = parent;
                    cur_next.acc = pick(parent.acc, ret_reg, smin_reg);
                    cur_next.ch  = parent.ch + 1'b1;
                    sp_next      = sp_reg - 1'b1;
                    state_next   = S_NEXT;
                end
            end

            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // clamp a count register write into 1..GRID_SIZE
    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped = CW'(1);
        end
        else if (int'(cfg_data) > GRID_SIZE)
        begin
            cfg_clamped = CW'(GRID_SIZE);
        end
    end

    // hold state, walk registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            nr_reg    <= CW'(64 > GRID_SIZE ? GRID_SIZE : 64);
            nc_reg    <= CW'(64 > GRID_SIZE ? GRID_SIZE : 64);
            smin_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_COUNT:  nr_reg   <= cfg_clamped;
                    REG_COL_COUNT:  nc_reg   <= cfg_clamped;
                    REG_SELECT_MIN: smin_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        qr1_reg     <= qr1_next;
        qc1_reg     <= qc1_next;
        qr2_reg     <= qr2_next;
        qc2_reg     <= qc2_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        ret_reg     <= ret_next;
        rd_grid_reg <= rd_grid_next;
        out_reg     <= out_next;
        if (push)
        begin
            stk_reg[sp_reg] <= cur_reg;
        end
    end

    // tree memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (tree_we)
        begin
            tree_mem[cur_reg.k] <= tree_wdata;
        end
        tree_q <= tree_mem[cur_reg.k];
    end

    // grid memory: load writes, build leaves read
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= in_ch.data.cell_value;
        end
        grid_q <= grid_mem[grid_raddr];
    end

endmodule

// ===== rtl/qre_checker.sv =====
// ----------------------------------------------------------------------------
// qre_checker
// Port-level checks of the quadtree range extreme query, bound to the top.
// ----------------------------------------------------------------------------
`include "quadtree_range_extreme_query_defines.svh"

module qre_checker
    import qre_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // one item at a time: busy right after acceptance
    `QRE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // no new item while a result waits
    `QRE_ASSERT(a_no_accept_with_result, out_valid |-> !in_ready, "ready with pending result")

    // stalled result holds
    `QRE_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
                     out_valid && $stable(out_data), "stalled result changed")

    // default point sits at the origin
    `QRE_ASSERT(a_default_origin,
                (out_valid && out_data.is_default) |->
                (out_data.best_row == '0 && out_data.best_col == '0),
                "default point off origin")

endmodule

bind quadtree_range_extreme_query qre_checker u_qre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
